>>> hdl/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-ASCII map of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] PAD_CHAR   = 8'd61;  // '='
   localparam logic [7:0] PLUS_CHAR  = 8'd43;  // '+'
   localparam logic [7:0] SLASH_CHAR = 8'd47;  // '/'

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   // one accepted byte, classified: up to two sextets, then '=' pads
   typedef struct packed {
      logic [5:0] sextet0;
      logic [5:0] sextet1;
      logic [1:0] count_m1;    // characters in the job minus one
      logic       final_flag;  // last character closes the message
   } job_type;

   function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
      logic [7:0] wide;
      wide = {2'b00, v};
      if (v <= 6'd25) begin
         sextet_to_ascii = wide + 8'd65;
      end else if (v <= 6'd51) begin
         sextet_to_ascii = wide + 8'd71;
      end else if (v <= 6'd61) begin
         sextet_to_ascii = wide - 8'd4;
      end else if (v == 6'd62) begin
         sextet_to_ascii = PLUS_CHAR;
      end else begin
         sextet_to_ascii = SLASH_CHAR;
      end
   endfunction

endpackage

>>> hdl/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Tracks the position in the three-byte group and the leftover bits, and
// turns each accepted byte into a job for the character serialiser.
// ----------------------------------------------------------------------------
module b64e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              final_byte,
   output b64e_pkg::job_type job
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [5:0]          carry_ff, carry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_0;
         carry_ff <= 6'd0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      carry_in       = carry_ff;
      job.final_flag = final_byte;
      unique case (phase_ff)
         b64e_pkg::PHASE_1: begin
            job.sextet0  = carry_ff | {2'b00, data_byte[7:4]};
            job.sextet1  = {data_byte[3:0], 2'b00};
            job.count_m1 = final_byte ? 2'd2 : 2'd0;
            if (accept) begin
               phase_in = b64e_pkg::PHASE_2;
               carry_in = {data_byte[3:0], 2'b00};
            end
         end
         b64e_pkg::PHASE_2: begin
            job.sextet0  = carry_ff | {4'b0000, data_byte[7:6]};
            job.sextet1  = data_byte[5:0];
            job.count_m1 = 2'd1;
            if (accept) begin
               phase_in = b64e_pkg::PHASE_0;
               carry_in = 6'd0;
            end
         end
         default: begin
            job.sextet0  = data_byte[7:2];
            job.sextet1  = {data_byte[1:0], 4'b0000};
            job.count_m1 = final_byte ? 2'd3 : 2'd0;
            if (accept) begin
               phase_in = b64e_pkg::PHASE_1;
               carry_in = {data_byte[1:0], 4'b0000};
            end
         end
      endcase
      if (accept && final_byte) begin
         phase_in = b64e_pkg::PHASE_0;
         carry_in = 6'd0;
      end
   end

endmodule

>>> hdl/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the classifier and the character serialiser.
// ----------------------------------------------------------------------------
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output b64e_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64e_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Character serialiser: walks the head job one character per cycle into the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  b64e_pkg::job_type job,
   output logic              job_pop,
   output logic              out_valid,
   output logic [7:0]        out_char,
   output logic              out_last,
   input  logic              out_ready
);

   logic [1:0] index_ff, index_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   assign load   = job_valid && (!valid_ff || out_ready);
   assign at_end = (index_ff == job.count_m1);
   assign job_pop = load && at_end;

   always_comb begin
      index_in = index_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         last_in  = job.final_flag && at_end;
         index_in = at_end ? 2'd0 : index_ff + 2'd1;
         unique case (index_ff)
            2'd0:    char_in = b64e_pkg::sextet_to_ascii(job.sextet0);
            2'd1:    char_in = b64e_pkg::sextet_to_ascii(job.sextet1);
            default: char_in = b64e_pkg::PAD_CHAR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

>>> hdl/base64_stream_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Byte stream in, standard Base64 characters out, '=' padded on the last byte.
// ----------------------------------------------------------------------------
//  channel  dir  tdata               tlast
//  req_     in   [7:0] data_byte     final_byte
//  rsp_     out  [7:0] out_char      end_of_text
//
//  A byte is taken whenever the job queue has room.
//  The serialiser emits one character per cycle while rsp_tready is high:
//  1 or 2 per byte, up to 4 on the final byte.
//  First character goes through the job queue and output register to rsp_.
//  Synchronous reset empties the queue and clears group position.
//  A stalled rsp_ holds its character; req_ stalls only when the queue fills.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // end_of_text
);

   b64e_pkg::job_type front_job;
   b64e_pkg::job_type head_job;
   logic              q_full;
   logic              head_valid;
   logic              head_pop;
   logic              accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .job        (front_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_job   (front_job),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .out_valid (rsp_tvalid),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

endmodule

>>> hdl/b64e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the encoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic pad_open_ff, pad_open_in;
   logic rsp_xfer;
   logic is_alpha;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // a '=' without tlast means a second '=' must be the next transaction
   always_comb begin
      pad_open_in = pad_open_ff;
      if (rsp_xfer) begin
         pad_open_in = (rsp_tdata == b64e_pkg::PAD_CHAR) && !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_open_ff <= 1'b0;
      end else begin
         pad_open_ff <= pad_open_in;
      end
   end

   assign is_alpha = (rsp_tdata >= 8'd65 && rsp_tdata <= 8'd90)
                  || (rsp_tdata >= 8'd97 && rsp_tdata <= 8'd122)
                  || (rsp_tdata >= 8'd48 && rsp_tdata <= 8'd57)
                  || (rsp_tdata == b64e_pkg::PLUS_CHAR)
                  || (rsp_tdata == b64e_pkg::SLASH_CHAR)
                  || (rsp_tdata == b64e_pkg::PAD_CHAR);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> is_alpha)
      else $error("rsp character outside the Base64 alphabet");

   a_pad_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && pad_open_ff |-> rsp_tdata == b64e_pkg::PAD_CHAR)
      else $error("single '=' not followed by a second pad");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid straight after reset");

   a_req_ready_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req not ready after reset");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/sv/base64_stream_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_core_tb
// Self-checking bench for the Base64 stream encoder. Messages of raw bytes go
// in on req_ (tlast on the final byte). An in-bench encoder builds the
// expected characters and their end-of-text flags, and each rsp_ transaction
// is checked in order against them. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core_tb;

   localparam int          CLK_HALF     = 6;
   localparam int          RESET_CYCLES = 12;
   localparam int          TARGET_BYTES = 400;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES = 10;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } raw_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } b64_char_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic       req_tlast  = 1'b0;    // final_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_char
   logic       rsp_tlast;            // end_of_text

   raw_byte_type   raw_bytes[$];
   b64_char_type   expected_chars[$];

   b64e_pkg::phase_type enc_phase = b64e_pkg::PHASE_0;
   logic [5:0]          enc_carry = '0;

   int unsigned mismatch_count = 0;
   int unsigned chars_seen     = 0;
   int unsigned send_gap       = 0;
   int unsigned send_calm      = 0;
   int unsigned recv_stall     = 0;
   int unsigned recv_calm      = 0;
   int unsigned idle_cycles    = 0;

   base64_stream_encoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < 6'd26) return 8'd65 + {2'b00, v};
      if (v < 6'd52) return 8'd97 + {2'b00, v} - 8'd26;
      if (v < 6'd62) return 8'd48 + {2'b00, v} - 8'd52;
      return (v == 6'd62) ? b64e_pkg::PLUS_CHAR : b64e_pkg::SLASH_CHAR;
   endfunction

   function automatic void expect_char(input logic [7:0] ch, input logic last);
      expected_chars.push_back('{ch, last});
   endfunction

   // one byte in, one to four characters out
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      unique case (enc_phase)
         b64e_pkg::PHASE_1: begin
            expect_char(sextet_char(enc_carry | {2'b00, b[7:4]}), 1'b0);
            enc_carry = {b[3:0], 2'b00};
            enc_phase = b64e_pkg::PHASE_2;
            if (fin) begin
               expect_char(sextet_char(enc_carry), 1'b0);
               expect_char(b64e_pkg::PAD_CHAR, 1'b1);
            end
         end
         b64e_pkg::PHASE_2: begin
            expect_char(sextet_char(enc_carry | {4'b0000, b[7:6]}), 1'b0);
            expect_char(sextet_char(b[5:0]), fin);
            enc_carry = '0;
            enc_phase = b64e_pkg::PHASE_0;
         end
         default: begin
            expect_char(sextet_char(b[7:2]), 1'b0);
            enc_carry = {b[1:0], 4'b0000};
            enc_phase = b64e_pkg::PHASE_1;
            if (fin) begin
               expect_char(sextet_char(enc_carry), 1'b0);
               expect_char(b64e_pkg::PAD_CHAR, 1'b0);
               expect_char(b64e_pkg::PAD_CHAR, 1'b1);
            end
         end
      endcase
      if (fin) begin
         enc_phase = b64e_pkg::PHASE_0;
         enc_carry = '0;
      end
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'hFB | 8'($urandom_range(0, 4));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_message(input logic [7:0] msg[]);
      foreach (msg[i]) raw_bytes.push_back('{msg[i], i == msg.size() - 1});
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (raw_bytes.size() > 0) begin
               raw_byte_type item;
               item = raw_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.data;
               req_tlast  <= item.fin;
               if (send_calm > 0) begin
                  send_calm--;
               end else if ($urandom_range(0, 49) == 0) begin
                  send_calm = $urandom_range(20, 60);
               end else begin
                  send_gap = pick_gap();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("char %0d: unexpected transaction %02h last=%0b",
                           chars_seen, rsp_tdata, rsp_tlast);
            end else begin
               b64_char_type exp_char;
               exp_char = expected_chars.pop_front();
               if (rsp_tdata !== exp_char.ch || rsp_tlast !== exp_char.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("char %0d: expected %02h last=%0b, got %02h last=%0b",
                              chars_seen, exp_char.ch, exp_char.last,
                              rsp_tdata, rsp_tlast);
               end
            end
            chars_seen++;
            if (recv_calm > 0) begin
               recv_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
               recv_calm = $urandom_range(20, 60);
            end else begin
               recv_stall = pick_gap();
            end
         end else if (recv_stall > 0) begin
            recv_stall--;
         end
         rsp_tready <= (recv_stall == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[base64_stream_encoder_core] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int unsigned total;
      int unsigned len;
      logic [7:0]  msg[];

      // directed: one, two and three byte tails, extremes, '+' and '/'
      queue_message('{8'h00});
      queue_message('{8'hFF});
      queue_message('{8'hFB, 8'hFF});
      queue_message('{8'h00, 8'h00, 8'h00});
      queue_message('{8'hFF, 8'hFF, 8'hFF});
      queue_message('{8'hFB, 8'hEF, 8'hBE});
      queue_message('{8'h4D, 8'h61, 8'h6E, 8'h4D});
      queue_message('{8'h68, 8'h65, 8'h6C, 8'h6C, 8'h6F});
      total = raw_bytes.size();

      // random messages, mostly short
      while (total < TARGET_BYTES) begin
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 9) : $urandom_range(10, 40);
         msg = new[len];
         foreach (msg[i]) msg[i] = pick_byte();
         queue_message(msg);
         total += len;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (raw_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("[base64_stream_encoder_core] OK");
      end else begin
         $display("[base64_stream_encoder_core] ERROR");
      end
      $finish;
   end

endmodule
